// ----- rtl/core/age_from_two_dates_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the age calculator
// Shared property wrappers, sampled on clk_i and quiet while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef AGE_FROM_TWO_DATES_DEFINES_SVH
`define AGE_FROM_TWO_DATES_DEFINES_SVH

// Same-cycle implication.
`define AFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define AFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/afd_pkg.sv -----
// ----------------------------------------------------------------------------
// afd_pkg
// Constants, unit codes and calendar helpers for the age calculator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package afd_pkg;

  localparam int YearW  = 14;
  localparam int FieldW = 7;
  localparam int AgeW   = 8;

  localparam logic [YearW-1:0]  MinYear       = 14'd1900;
  localparam logic [AgeW-1:0]   MaxAgeReset   = 8'd120;
  localparam logic [FieldW-1:0] MonthsPerYear = 7'd12;

  // ceil(2^24 / 25); low 24 bits of year * Div25Mul fall below it exactly
  // when the year is a multiple of 25 (holds for all 14-bit years)
  localparam logic [23:0] Div25Mul = 24'd671089;

  typedef enum logic [1:0] {
    UNIT_YEARS  = 2'd0,
    UNIT_MONTHS = 2'd1,
    UNIT_DAYS   = 2'd2
  } afd_unit_e;

  function automatic logic is_leap(input logic [YearW-1:0] year);
    logic [23:0] prod;
    logic        div25;
    prod  = {10'd0, year} * Div25Mul;
    div25 = (prod < Div25Mul);
    // div by 4, and not by 100 unless by 400 (100 = 4*25, 400 = 16*25)
    return (year[1:0] == 2'd0) && (!div25 || (year[3:0] == 4'd0));
  endfunction

  function automatic logic [4:0] days_in_month(input logic [FieldW-1:0] month,
                                               input logic leap);
    logic [4:0] len;
    unique case (month)
      7'd2:                                           len = 5'd28 + {4'd0, leap};
      7'd4, 7'd6, 7'd9, 7'd11:                        len = 5'd30;
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12:     len = 5'd31;
      default:                                        len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic date_ok(input logic [YearW-1:0]  year,
                                   input logic [FieldW-1:0] month,
                                   input logic [FieldW-1:0] day);
    logic [4:0] len;
    len = days_in_month(month, is_leap(year));
    // bad months give a zero length, which fails the day check
    return (year >= MinYear) && (day != 7'd0) && (day <= {2'b00, len});
  endfunction

endpackage

// ----- rtl/core/age_from_two_dates.sv -----
// ----------------------------------------------------------------------------
// age_from_two_dates
// Age at a study date from a birth date, reported in years, months or days.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_ready_o carries one birth date and one study
//   date per transfer. Output channel out_valid_o / out_ready_i returns one
//   result per input: age_valid_o, age_unit_o (0 years, 1 months, 2 days) and
//   age_value_o. Invalid results carry zero unit and value.
//   An item taken into the input register moves on to the result register
//   when that register is free, with the date checks and the subtraction
//   between them. Throughput is one item per cycle unless the receiver stalls.
//   When the receiver stalls, the result register holds and the input register
//   still takes one more item; in_ready_o drops only when both are full.
//   cfg_we_i writes max_age_years from cfg_wdata_i; write it only
//   while no item is in flight.
//   Reset empties both stages and sets max_age_years to 120.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module age_from_two_dates
  import afd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [AgeW-1:0]   cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [YearW-1:0]  birth_year_i,
  input  logic [FieldW-1:0] birth_month_i,
  input  logic [FieldW-1:0] birth_day_i,
  input  logic [YearW-1:0]  study_year_i,
  input  logic [FieldW-1:0] study_month_i,
  input  logic [FieldW-1:0] study_day_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              age_valid_o,
  output logic [1:0]        age_unit_o,
  output logic [AgeW-1:0]   age_value_o
);

  `include "age_from_two_dates_defines.svh"

  logic [AgeW-1:0]   max_age_q;

  logic              in_vld_q;
  logic [YearW-1:0]  by_q, sy_q;
  logic [FieldW-1:0] bm_q, bd_q, sm_q, sd_q;

  logic              out_vld_q;
  logic              res_valid_q, res_valid_d;
  afd_unit_e         res_unit_q, res_unit_d;
  logic [AgeW-1:0]   res_value_q, res_value_d;

  logic              res_ready;
  logic              in_xfer;

  logic              dates_ok;
  logic              s_leap;
  logic [FieldW-1:0] prev_month;
  logic [4:0]        borrow_len;
  logic signed [8:0] day_diff, day_adj;
  logic              day_borrow;
  logic signed [8:0] month_diff, month_adj;
  logic              month_borrow;
  logic signed [15:0] year_diff;

  // Handshake
  assign res_ready  = !out_vld_q || out_ready_i;
  assign in_ready_o = !in_vld_q || res_ready;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_age_q <= MaxAgeReset;
    end else if (cfg_we_i) begin
      max_age_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (res_ready) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      by_q <= birth_year_i;
      bm_q <= birth_month_i;
      bd_q <= birth_day_i;
      sy_q <= study_year_i;
      sm_q <= study_month_i;
      sd_q <= study_day_i;
    end
  end

  // Date difference
  assign dates_ok   = date_ok(by_q, bm_q, bd_q) && date_ok(sy_q, sm_q, sd_q);
  assign s_leap     = is_leap(sy_q);
  assign prev_month = (sm_q == 7'd1) ? MonthsPerYear : sm_q - 7'd1;
  assign borrow_len = days_in_month(prev_month, s_leap);

  assign day_diff   = $signed({2'b00, sd_q}) - $signed({2'b00, bd_q});
  assign day_borrow = day_diff[8];
  assign day_adj    = day_borrow ? day_diff + $signed({4'b0000, borrow_len}) : day_diff;

  // borrow one month when the day went negative
  assign month_diff   = $signed({2'b00, sm_q}) - $signed({8'd0, day_borrow})
                      - $signed({2'b00, bm_q});
  assign month_borrow = month_diff[8];
  assign month_adj    = month_borrow ? month_diff + $signed({2'b00, MonthsPerYear})
                                     : month_diff;

  assign year_diff = $signed({2'b00, sy_q}) - $signed({2'b00, by_q})
                   - $signed({15'd0, month_borrow});

  always_comb begin
    res_valid_d = 1'b0;
    res_unit_d  = UNIT_YEARS;
    res_value_d = '0;
    priority if (!dates_ok) begin
      res_valid_d = 1'b0;
    end else if (year_diff[15] || (year_diff > $signed({8'd0, max_age_q}))) begin
      res_valid_d = 1'b0;
    end else if (year_diff != 16'sd0) begin
      res_valid_d = 1'b1;
      res_unit_d  = UNIT_YEARS;
      res_value_d = year_diff[AgeW-1:0];
    end else if (month_adj > 9'sd0) begin
      res_valid_d = 1'b1;
      res_unit_d  = UNIT_MONTHS;
      res_value_d = month_adj[AgeW-1:0];
    end else if (!day_adj[8]) begin
      res_valid_d = 1'b1;
      res_unit_d  = UNIT_DAYS;
      res_value_d = (day_adj == 9'sd0) ? 8'd1 : day_adj[AgeW-1:0];
    end else begin
      // borrow month too short to cover the day gap
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready) begin
      res_valid_q <= res_valid_d;
      res_unit_q  <= res_unit_d;
      res_value_q <= res_value_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign age_valid_o = res_valid_q;
  assign age_unit_o  = res_unit_q;
  assign age_value_o = res_value_q;

  // Checks
  `AFD_ASSERT_NEXT(a_stage_advance, in_vld_q && res_ready, out_vld_q,
    "input stage item did not reach result register")
  `AFD_ASSERT_NOW(a_invalid_zero, out_vld_q && !res_valid_q,
    (res_unit_q == UNIT_YEARS) && (res_value_q == '0),
    "invalid result carries nonzero unit or value")
  `AFD_ASSERT_NOW(a_days_nonzero, out_vld_q && res_valid_q && (res_unit_q == UNIT_DAYS),
    (res_value_q != '0) && (res_value_q < 8'd31),
    "day age out of range")
  `AFD_ASSERT_NOW(a_years_bound, out_vld_q && res_valid_q && (res_unit_q == UNIT_YEARS),
    (res_value_q != '0) && (res_value_q <= max_age_q),
    "year age outside 1 to max_age_years")

endmodule
